>>> rtl/ddc_pkg.sv
package ddc_pkg;

  localparam int unsigned AddrW = 7;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 4;

  localparam logic [AddrW-1:0] SlaveAddrRst = 7'h50;
  localparam logic [CntW-1:0]  BitsPerByte  = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_ADDR      = 4'd1,
    PH_ADDR_ACK  = 4'd2,
    PH_OFFS      = 4'd3,
    PH_OFFS_ACK  = 4'd4,
    PH_SEND      = 4'd5,
    PH_HOST_ACK  = 4'd6,
    PH_ADDR_HOLD = 4'd7,
    PH_OFFS_HOLD = 4'd8
  } ddc_phase_e;

  typedef struct packed {
    ddc_phase_e       phase;
    logic [ByteW-1:0] shifter;
    logic [CntW-1:0]  bit_count;
    logic [ByteW-1:0] latched_addr;
    logic [ByteW-1:0] rom_ptr;
    logic             released;
    logic             prev_scl;
    logic             prev_sda;
  } ddc_state_t;

  typedef struct packed {
    logic byte_done;
    logic address_hit;
    logic start_pulse;
    logic sda_release;
  } ddc_result_t;

  // EDID block; offsets 128..255 read as zero, offset 127 is the checksum
  function automatic logic [ByteW-1:0] rom_byte(input logic [ByteW-1:0] at);
    logic [ByteW-1:0] b;
    case (at)
      8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6: b = 8'hFF;
      8'd8:   b = 8'h06;
      8'd9:   b = 8'h10;
      8'd10:  b = 8'h01;
      8'd11:  b = 8'h9D;
      8'd16:  b = 8'h0A;
      8'd17:  b = 8'h0B;
      8'd18:  b = 8'h01;
      8'd19:  b = 8'h03;
      8'd20:  b = 8'h0E;
      8'd21:  b = 8'h22;
      8'd22:  b = 8'h1B;
      8'd23:  b = 8'h78;
      8'd24:  b = 8'h0D;
      8'd35:  b = 8'h21;
      8'd54:  b = 8'h31;
      8'd55:  b = 8'h40;
      8'd56:  b = 8'h80;
      8'd57:  b = 8'hE0;
      8'd59:  b = 8'h18;
      8'd60:  b = 8'h10;
      8'd61:  b = 8'h20;
      8'd127: b = 8'h2F;  // bytes 0..126 sum to 0xD1 mod 256
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/ddc_step.sv
module ddc_step
  import ddc_pkg::*;
(
  input  ddc_state_t       state_i,
  input  logic             scl_i,
  input  logic             sda_i,
  input  logic [AddrW-1:0] slave_addr_i,
  output ddc_state_t       state_o,
  output ddc_result_t      result_o
);

  logic             sampled;
  logic [ByteW-1:0] shifted;
  logic [CntW-1:0]  cnt_inc;
  logic             rise;
  logic             fall;

  // own pull-down reads back as zero
  assign sampled = sda_i & state_i.released;
  assign shifted = {state_i.shifter[ByteW-2:0], sampled};
  assign cnt_inc = state_i.bit_count + 1'b1;
  assign rise    = scl_i & ~state_i.prev_scl;
  assign fall    = ~scl_i & state_i.prev_scl;

  always_comb begin
    state_o  = state_i;
    result_o = '0;

    if (state_i.prev_scl && scl_i && (sda_i != state_i.prev_sda)) begin
      // START or STOP
      if (!sda_i) begin
        result_o.start_pulse = 1'b1;
        state_o.phase        = PH_ADDR;
        state_o.shifter      = '0;
        state_o.bit_count    = '0;
      end else begin
        state_o.phase = PH_IDLE;
      end
      state_o.released = 1'b1;
      state_o.prev_sda = sda_i;
    end else begin
      if (rise) begin
        case (state_i.phase)
          PH_ADDR: begin
            state_o.shifter   = shifted;
            state_o.bit_count = cnt_inc;
            if (cnt_inc == BitsPerByte) begin
              state_o.latched_addr = shifted;
              state_o.bit_count    = '0;
              if (shifted[ByteW-1:1] == slave_addr_i) begin
                state_o.phase        = PH_ADDR_ACK;
                result_o.address_hit = 1'b1;
              end else begin
                state_o.phase = PH_IDLE;
              end
            end
          end
          PH_OFFS: begin
            state_o.shifter   = shifted;
            state_o.bit_count = cnt_inc;
            if (cnt_inc == BitsPerByte) begin
              state_o.rom_ptr   = shifted;
              state_o.bit_count = '0;
              state_o.phase     = PH_OFFS_ACK;
            end
          end
          PH_ADDR_HOLD: begin
            if (state_i.latched_addr[0]) begin
              state_o.phase   = PH_SEND;
              state_o.shifter = rom_byte(state_i.rom_ptr);
            end else begin
              state_o.phase   = PH_OFFS;
              state_o.shifter = '0;
            end
            state_o.bit_count = '0;
          end
          PH_OFFS_HOLD: begin
            state_o.phase     = PH_OFFS;
            state_o.bit_count = '0;
          end
          PH_SEND: begin
            state_o.bit_count = cnt_inc;
            if (cnt_inc == BitsPerByte) begin
              state_o.bit_count  = '0;
              state_o.phase      = PH_HOST_ACK;
              result_o.byte_done = 1'b1;
              state_o.rom_ptr    = state_i.rom_ptr + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end else if (fall) begin
        case (state_i.phase)
          PH_ADDR_ACK: begin
            state_o.released = 1'b0;
            state_o.phase    = PH_ADDR_HOLD;
          end
          PH_OFFS_ACK: begin
            state_o.released = 1'b0;
            state_o.phase    = PH_OFFS_HOLD;
          end
          PH_SEND: begin
            state_o.released = state_i.shifter[3'd7 - state_i.bit_count[2:0]];
          end
          PH_HOST_ACK: begin
            state_o.released  = 1'b1;
            state_o.phase     = PH_SEND;
            state_o.shifter   = rom_byte(state_i.rom_ptr);
            state_o.bit_count = '0;
          end
          default: begin
            state_o.released = 1'b1;
          end
        endcase
      end
      state_o.prev_scl = scl_i;
      state_o.prev_sda = sda_i;
    end

    result_o.sda_release = state_o.released;
  end

endmodule

>>> rtl/ddc_edid_i2c_slave_top.sv
// A result is registered and shows in the cycle after its sample is accepted.
// One sample per cycle unless the output stalls; the bus state and the result
// register update together; the next sample is taken while a result is taken.
// Reset: rst_ni is asynchronous, active low; the bus state goes idle with SDA
// released, the slave address returns to 0x50 and the result register empties.
module ddc_edid_i2c_slave_top
  import ddc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [0] scl_level, [1] sda_level
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [0] sda_release, [1] start_pulse,
                                           // [2] address_hit, [3] byte_done
);

  logic [AddrW-1:0] slave_addr_q;
  ddc_state_t       state_q, state_d;
  ddc_result_t      result_d, result_q;
  logic             out_valid_q;
  logic             accept;

  ddc_step u_step (
    .state_i     (state_q),
    .scl_i       (s_axis_tdata[0]),
    .sda_i       (s_axis_tdata[1]),
    .slave_addr_i(slave_addr_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  // a request moves in when the result slot is empty or draining this cycle
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q         <= SlaveAddrRst;
      state_q.phase        <= PH_IDLE;
      state_q.shifter      <= '0;
      state_q.bit_count    <= '0;
      state_q.latched_addr <= '0;
      state_q.rom_ptr      <= '0;
      state_q.released     <= 1'b1;
      state_q.prev_scl     <= 1'b1;
      state_q.prev_sda     <= 1'b1;
      out_valid_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slave_addr_q <= cfg_wdata_i;
      end
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, result_q.byte_done, result_q.address_hit,
                          result_q.start_pulse, result_q.sda_release};

endmodule

>>> rtl/ddc_chk.sv
module ddc_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // every accepted sample yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted sample produced no result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // START and address match both leave SDA released
  a_start_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("START with SDA driven low");

  a_hit_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[0])
    else $error("address match with SDA driven low");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[3:1]))
    else $error("more than one event flag in one result");

endmodule

bind ddc_edid_i2c_slave_top ddc_chk u_ddc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> sim/tb_ddc_edid_i2c_slave_top.sv
`timescale 1ns / 1ps

module tb_ddc_edid_i2c_slave_top;
  import ddc_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned ItemsPerAddr = 190;
  localparam int unsigned DrainCycles  = 4;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [AddrW-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;  // [0] scl_level, [1] sda_level
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;        // [0] sda_release, [1] start_pulse,
                                         // [2] address_hit, [3] byte_done

  ddc_edid_i2c_slave_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]  pin_q[$];
  ddc_result_t exp_drive_q[$];
  logic [7:0]  edid_img[128];

  // slave model state
  ddc_phase_e       bus_phase;
  logic [ByteW-1:0] rx_shift;
  logic [CntW-1:0]  bit_cnt;
  logic [ByteW-1:0] addr_byte;
  logic [ByteW-1:0] edid_ptr;
  logic             sda_free;
  logic             last_scl;
  logic             last_sda;
  logic [AddrW-1:0] own_addr;

  int n_pushed    = 0;
  int n_taken     = 0;
  int n_results   = 0;
  int n_errors    = 0;
  int n_starts    = 0;
  int n_hits      = 0;
  int n_bytes_out = 0;
  int n_holds     = 0;
  int cycle_cnt   = 0;
  int drv_gap     = 0;
  int rx_wait     = 0;
  int rx_hold     = 0;
  bit in_taken    = 1'b0;
  bit out_taken   = 1'b0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;

  function automatic logic [7:0] edid_at(input logic [7:0] at);
    return at[7] ? 8'h00 : edid_img[at[6:0]];
  endfunction

  function automatic ddc_result_t predict_bus_sample(input logic scl, input logic sda);
    ddc_result_t r;
    logic        bit_in;
    r = '0;
    if (last_scl && scl && sda != last_sda) begin
      // START or STOP while SCL is high
      if (!sda) begin
        r.start_pulse = 1'b1;
        n_starts++;
        bus_phase = PH_ADDR;
        rx_shift  = '0;
        bit_cnt   = '0;
      end else begin
        bus_phase = PH_IDLE;
      end
      sda_free = 1'b1;
      last_sda = sda;
    end else begin
      if (scl && !last_scl) begin
        bit_in = sda & sda_free;  // own pull-down reads back as 0
        case (bus_phase)
          PH_ADDR, PH_OFFS: begin
            rx_shift = {rx_shift[6:0], bit_in};
            bit_cnt  = bit_cnt + 1'b1;
            if (bit_cnt == BitsPerByte) begin
              bit_cnt = '0;
              if (bus_phase == PH_OFFS) begin
                edid_ptr  = rx_shift;
                bus_phase = PH_OFFS_ACK;
              end else begin
                addr_byte = rx_shift;
                if (rx_shift[7:1] == own_addr) begin
                  bus_phase     = PH_ADDR_ACK;
                  r.address_hit = 1'b1;
                  n_hits++;
                end else begin
                  bus_phase = PH_IDLE;
                end
              end
            end
          end
          PH_ADDR_HOLD: begin
            if (addr_byte[0]) begin
              bus_phase = PH_SEND;
              rx_shift  = edid_at(edid_ptr);
            end else begin
              bus_phase = PH_OFFS;
              rx_shift  = '0;
            end
            bit_cnt = '0;
          end
          PH_OFFS_HOLD: begin
            bus_phase = PH_OFFS;
            bit_cnt   = '0;
          end
          PH_SEND: begin
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt == BitsPerByte) begin
              bit_cnt     = '0;
              bus_phase   = PH_HOST_ACK;
              r.byte_done = 1'b1;
              n_bytes_out++;
              edid_ptr    = edid_ptr + 1'b1;
            end
          end
          default: ;
        endcase
      end else if (!scl && last_scl) begin
        case (bus_phase)
          PH_ADDR_ACK: begin
            sda_free  = 1'b0;
            bus_phase = PH_ADDR_HOLD;
          end
          PH_OFFS_ACK: begin
            sda_free  = 1'b0;
            bus_phase = PH_OFFS_HOLD;
          end
          PH_SEND: sda_free = rx_shift[3'd7 - bit_cnt[2:0]];
          PH_HOST_ACK: begin
            sda_free  = 1'b1;
            bus_phase = PH_SEND;
            rx_shift  = edid_at(edid_ptr);
            bit_cnt   = '0;
          end
          default: sda_free = 1'b1;
        endcase
      end
      last_scl = scl;
      last_sda = sda;
    end
    r.sda_release = sda_free;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic want, input logic got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s expected %0b, got %0b", $time, fname, want, got);
    end
  endtask

  // bus sequence builders; every sequence leaves SCL low except STOP
  task automatic put_pins(input logic scl, input logic sda);
    int reps;
    reps = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1;
    repeat (reps) begin
      pin_q.insert(pin_q.size(), {6'b0, sda, scl});
      n_pushed++;
    end
  endtask

  task automatic bus_start();
    put_pins(1'b0, 1'b1);
    put_pins(1'b1, 1'b1);
    put_pins(1'b1, 1'b0);
    put_pins(1'b0, 1'b0);
  endtask

  task automatic bus_stop();
    put_pins(1'b0, 1'b0);
    put_pins(1'b1, 1'b0);
    put_pins(1'b1, 1'b1);
  endtask

  task automatic bus_bit(input logic b);
    put_pins(1'b0, b);
    put_pins(1'b1, b);
    put_pins(1'b0, b);
  endtask

  task automatic bus_write_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) bus_bit(v[i]);
    bus_bit(1'b1);  // master releases for the slave ACK
  endtask

  task automatic bus_read_byte(input logic ack_level);
    repeat (8) bus_bit(1'b1);
    bus_bit(ack_level);
  endtask

  task automatic bus_read(input logic [6:0] a, input int nbytes);
    bus_start();
    bus_write_byte({a, 1'b1});
    for (int i = 0; i < nbytes; i++)
      bus_read_byte((i == nbytes - 1) ? 1'b1 : ($urandom_range(0, 9) == 0));
    bus_stop();
  endtask

  task automatic bus_offset_read(input logic [6:0] a, input logic [7:0] offs,
                                 input int nbytes);
    bus_start();
    bus_write_byte({a, 1'b0});
    bus_write_byte(offs);
    bus_read(a, nbytes);  // repeated START
  endtask

  task automatic bus_transaction(input logic [6:0] tgt);
    int         kind;
    int         nbytes;
    logic [6:0] a;
    logic [7:0] offs;
    kind   = $urandom_range(0, 19);
    a      = ($urandom_range(0, 7) == 0) ? 7'($urandom) : tgt;
    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    case ($urandom_range(0, 3))
      0:       offs = 8'($urandom_range(123, 129));
      1:       offs = 8'($urandom_range(250, 255));
      default: offs = 8'($urandom);
    endcase
    if (kind < 9) begin
      bus_offset_read(a, offs, nbytes);
    end else if (kind < 12) begin
      bus_start();
      bus_write_byte({a, 1'b0});
      repeat ($urandom_range(1, 2)) bus_write_byte(8'($urandom));
      bus_stop();
    end else if (kind < 16) begin
      bus_read(a, nbytes);
    end else if (kind < 18) begin
      // request cut short
      bus_start();
      bus_write_byte({a, 1'($urandom)});
      repeat ($urandom_range(1, 17)) bus_bit(1'($urandom));
      if ($urandom_range(0, 1)) bus_stop();
    end else begin
      repeat ($urandom_range(4, 16)) put_pins(1'($urandom), 1'($urandom));
    end
  endtask

  task automatic wait_bus_drained();
    while (n_taken != n_pushed || exp_drive_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !in_taken)) begin
      if (drv_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (pin_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pin_q.pop_front();
        if ($urandom_range(0, 63) == 0) tx_burst <= !tx_burst;
        drv_gap <= tx_burst ? 0 : $urandom_range(0, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with a few long hold-offs to back the block up
  always @(negedge clk_i) begin
    int rx_draw;
    if (rst_ni) begin
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (out_taken) begin
        if ($urandom_range(0, 63) == 0) rx_burst <= !rx_burst;
        if (n_results % 400 == 250) begin
          m_axis_tready <= 1'b0;
          rx_hold <= 300;
          n_holds++;
        end else if (rx_burst) begin
          m_axis_tready <= 1'b1;
        end else begin
          rx_draw = $urandom_range(0, 18);
          rx_wait <= rx_draw;
          m_axis_tready <= (rx_draw == 0);
        end
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        m_axis_tready <= (rx_wait == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    ddc_result_t got;
    ddc_result_t want;
    in_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got = ddc_result_t'(m_axis_tdata[3:0]);
      if (exp_drive_q.size() == 0) begin
        n_errors++;
        $display("%0t: result %h with none expected", $time, m_axis_tdata);
      end else begin
        want = exp_drive_q.pop_front();
        check_field("sda_release", want.sda_release, got.sda_release);
        check_field("start_pulse", want.start_pulse, got.start_pulse);
        check_field("address_hit", want.address_hit, got.address_hit);
        check_field("byte_done", want.byte_done, got.byte_done);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      n_taken++;
      exp_drive_q.insert(exp_drive_q.size(),
                         predict_bus_sample(s_axis_tdata[0], s_axis_tdata[1]));
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout, %0d requests outstanding", $time, exp_drive_q.size());
      $display("tb_ddc_edid_i2c_slave_top failed");
      $finish;
    end
  end

  initial begin
    int         sum;
    int         target;
    logic [6:0] addr_set[4];

    edid_img = '{default: 8'h00};
    for (int k = 1; k <= 6; k++) edid_img[k] = 8'hFF;
    edid_img[8]  = 8'h06; edid_img[9]  = 8'h10; edid_img[10] = 8'h01; edid_img[11] = 8'h9D;
    edid_img[16] = 8'h0A; edid_img[17] = 8'h0B; edid_img[18] = 8'h01; edid_img[19] = 8'h03;
    edid_img[20] = 8'h0E; edid_img[21] = 8'h22; edid_img[22] = 8'h1B; edid_img[23] = 8'h78;
    edid_img[24] = 8'h0D; edid_img[35] = 8'h21;
    edid_img[54] = 8'h31; edid_img[55] = 8'h40; edid_img[56] = 8'h80; edid_img[57] = 8'hE0;
    edid_img[59] = 8'h18; edid_img[60] = 8'h10; edid_img[61] = 8'h20;
    sum = 0;
    for (int k = 0; k < 127; k++) sum += edid_img[k];
    edid_img[127] = 8'h00 - 8'(sum);  // block sums to zero

    bus_phase = PH_IDLE;
    rx_shift  = '0;
    bit_cnt   = '0;
    addr_byte = '0;
    edid_ptr  = '0;
    sda_free  = 1'b1;
    last_scl  = 1'b1;
    last_sda  = 1'b1;
    own_addr  = SlaveAddrRst;

    addr_set = '{SlaveAddrRst, 7'h00, 7'h7F, 7'($urandom_range(1, 126))};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // stray edges while idle, lone START/STOP, edge with data change
    put_pins(1'b1, 1'b1);
    put_pins(1'b0, 1'b1);
    put_pins(1'b0, 1'b0);
    put_pins(1'b1, 1'b0);
    put_pins(1'b1, 1'b1);
    put_pins(1'b1, 1'b0);
    put_pins(1'b0, 1'b0);
    put_pins(1'b1, 1'b1);
    put_pins(1'b1, 1'b0);
    put_pins(1'b1, 1'b1);

    foreach (addr_set[i]) begin
      wait_bus_drained();
      @(negedge clk_i);
      cfg_wdata_i <= addr_set[i];
      cfg_we_i <= 1'b1;
      own_addr = addr_set[i];
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      target = n_pushed + ItemsPerAddr;
      if (i == 0) begin
        // checksum byte and the zero region, pointer wrap, address miss
        bus_offset_read(addr_set[i], 8'd126, 3);
        bus_offset_read(addr_set[i], 8'd254, 3);
        bus_read(addr_set[i] ^ 7'h01, 1);
      end
      while (n_pushed < target) bus_transaction(addr_set[i]);
    end

    wait_bus_drained();
    $display("Ran %0d bus samples against %0d slave addresses, with %0d long output stalls.",
             n_taken, $size(addr_set), n_holds);
    $display("Saw %0d STARTs, %0d address matches and %0d EDID bytes sent.",
             n_starts, n_hits, n_bytes_out);
    if (n_errors == 0) begin
      $display("tb_ddc_edid_i2c_slave_top passed");
    end else begin
      $display("tb_ddc_edid_i2c_slave_top failed");
    end
    $finish;
  end

endmodule
